@@ hdl/efp_pkg.sv @@
// Shared constants, configuration and token types for the escape-time fractal pixel block.
`timescale 1ns / 1ps

package efp_pkg;

	localparam int FRAC_BITS  = 28;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int NUM_CELLS  = 4;

	localparam int COL_W   = 10;
	localparam int ROW_W   = 10;
	localparam int COORD_W = 32;
	localparam int STEP_W  = 31;
	localparam int LIM_W   = 16;
	localparam int CNT_OUT_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// z and c hold origin plus up to 1023 steps, plus headroom for the update sum
	localparam int Z_W   = STEP_W + COL_W + 3;
	// |z| < 2 inside the loop, so FRAC_BITS + 2 signed bits carry the operand
	localparam int MUL_W = FRAC_BITS + 2;
	// floored products stay below 4
	localparam int SQ_W  = FRAC_BITS + 4;

	localparam logic signed [Z_W-1:0] TWO_Z = Z_W'(64'd2 << FRAC_BITS);
	localparam logic [SQ_W:0] FOUR_SUM = (SQ_W + 1)'(64'd4 << FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_JULIA_MODE = 3'd0,
		CFG_ITER_LIMIT = 3'd1,
		CFG_ORIGIN_RE  = 3'd2,
		CFG_ORIGIN_IM  = 3'd3,
		CFG_PIXEL_STEP = 3'd4,
		CFG_JULIA_C_RE = 3'd5,
		CFG_JULIA_C_IM = 3'd6
	} cfg_index_t;

	localparam logic [LIM_W-1:0]   RST_ITER_LIMIT = 16'd255;
	localparam logic [COORD_W-1:0] RST_ORIGIN     = 32'hE000_0000;
	localparam logic [STEP_W-1:0]  RST_PIXEL_STEP = 31'd2684355;

	typedef struct packed {
		logic                      julia_mode;
		logic [LIM_W-1:0]          iteration_limit;
		logic signed [COORD_W-1:0] origin_re;
		logic signed [COORD_W-1:0] origin_im;
		logic [STEP_W-1:0]         pixel_step;
		logic signed [COORD_W-1:0] julia_c_re;
		logic signed [COORD_W-1:0] julia_c_im;
	} cfg_t;

	// one pixel in flight through the cell ring
	typedef struct packed {
		logic                  valid;
		logic                  done;
		logic signed [Z_W-1:0] zre;
		logic signed [Z_W-1:0] zim;
		logic signed [Z_W-1:0] cre;
		logic signed [Z_W-1:0] cim;
		logic [LIM_W-1:0]      count;
	} token_t;

endpackage

@@ hdl/efp_map.sv @@
// Maps a pixel request to its complex start point and launches a token into the ring.
`timescale 1ns / 1ps

module efp_map (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [efp_pkg::COL_W-1:0]      column,
	input  logic [efp_pkg::ROW_W-1:0]      row,
	input  efp_pkg::cfg_t                  cfg,
	output efp_pkg::token_t                tok_out
);

	localparam int OFF_W = efp_pkg::COL_W + efp_pkg::STEP_W;

	logic [OFF_W-1:0]                  off_re;
	logic [OFF_W-1:0]                  off_im;
	logic signed [efp_pkg::Z_W-1:0]    pt_re;
	logic signed [efp_pkg::Z_W-1:0]    pt_im;
	logic                              outside;
	efp_pkg::token_t                   tok_d;
	efp_pkg::token_t                   tok_q;
	logic                              valid_q;

	assign off_re = OFF_W'(column) * OFF_W'(cfg.pixel_step);
	assign off_im = OFF_W'(row) * OFF_W'(cfg.pixel_step);
	assign pt_re  = efp_pkg::Z_W'(cfg.origin_re) + $signed(efp_pkg::Z_W'(off_re));
	assign pt_im  = efp_pkg::Z_W'(cfg.origin_im) + $signed(efp_pkg::Z_W'(off_im));

	assign outside = ({1'b0, column} >= (efp_pkg::COL_W + 1)'(efp_pkg::MAX_WIDTH)) ||
		({1'b0, row} >= (efp_pkg::ROW_W + 1)'(efp_pkg::MAX_HEIGHT));

	always_comb begin
		tok_d       = '0;
		tok_d.valid = 1'b1;
		tok_d.done  = outside;
		if (cfg.julia_mode) begin
			tok_d.zre = pt_re;
			tok_d.zim = pt_im;
			tok_d.cre = efp_pkg::Z_W'(cfg.julia_c_re);
			tok_d.cim = efp_pkg::Z_W'(cfg.julia_c_im);
		end else begin
			tok_d.cre = pt_re;
			tok_d.cim = pt_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q <= tok_d;
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

@@ hdl/efp_cell.sv @@
// One ring cell: escape test and one z = z^2 + c step, registered towards the next cell.
`timescale 1ns / 1ps

module efp_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [efp_pkg::LIM_W-1:0]   limit,
	input  efp_pkg::token_t             tok_in,
	output efp_pkg::token_t             tok_out
);

	logic signed [efp_pkg::MUL_W-1:0]   re_m;
	logic signed [efp_pkg::MUL_W-1:0]   im_m;
	logic signed [2*efp_pkg::MUL_W-1:0] p_rr;
	logic signed [2*efp_pkg::MUL_W-1:0] p_ii;
	logic signed [2*efp_pkg::MUL_W-1:0] p_ri;
	logic signed [efp_pkg::SQ_W-1:0]    sq_re;
	logic signed [efp_pkg::SQ_W-1:0]    sq_im;
	logic signed [efp_pkg::SQ_W-1:0]    pr;
	logic [efp_pkg::SQ_W:0]             mag_sum;
	logic                               in_disk;
	efp_pkg::token_t                    nxt;
	efp_pkg::token_t                    tok_q;
	logic                               valid_q;

	// operands only matter when both parts of z lie within (-2, 2), where the low bits hold the whole value
	assign re_m = $signed(tok_in.zre[efp_pkg::MUL_W-1:0]);
	assign im_m = $signed(tok_in.zim[efp_pkg::MUL_W-1:0]);

	assign p_rr = re_m * re_m;
	assign p_ii = im_m * im_m;
	assign p_ri = re_m * im_m;

	// arithmetic shift floors towards minus infinity
	assign sq_re = efp_pkg::SQ_W'(p_rr >>> efp_pkg::FRAC_BITS);
	assign sq_im = efp_pkg::SQ_W'(p_ii >>> efp_pkg::FRAC_BITS);
	assign pr    = efp_pkg::SQ_W'(p_ri >>> efp_pkg::FRAC_BITS);

	assign mag_sum = {1'b0, sq_re} + {1'b0, sq_im};

	assign in_disk = (tok_in.zre < efp_pkg::TWO_Z) && (tok_in.zre > -efp_pkg::TWO_Z) &&
		(tok_in.zim < efp_pkg::TWO_Z) && (tok_in.zim > -efp_pkg::TWO_Z);

	always_comb begin
		nxt = tok_in;
		if (!tok_in.done) begin
			if ((tok_in.count >= limit) || !in_disk || (mag_sum >= efp_pkg::FOUR_SUM)) begin
				nxt.done = 1'b1;
			end else begin
				nxt.zre   = efp_pkg::Z_W'(sq_re) - efp_pkg::Z_W'(sq_im) + tok_in.cre;
				nxt.zim   = (efp_pkg::Z_W'(pr) <<< 1) + tok_in.cim;
				nxt.count = tok_in.count + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			tok_q <= nxt;
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

@@ hdl/escape_time_fractal_pixel_top.sv @@
// Top level of the escape-time fractal pixel block: configuration, request handshake, cell ring.
// A single token circulates the cell ring, one iteration per cell per cycle until it is done,
// so a new request is taken only after the last one has left the ring.
// A finished result waits in the output register while the next request is taken.
// Reset: registers return to defaults (Mandelbrot, limit 255, origin -2-2i), ring empties.
`timescale 1ns / 1ps

module escape_time_fractal_pixel_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [efp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [efp_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [efp_pkg::COL_W-1:0]         column,
	input  logic [efp_pkg::ROW_W-1:0]         row,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [efp_pkg::CNT_OUT_W-1:0]     escape_count
);

	efp_pkg::cfg_t                 cfg_q;
	logic                          busy_q;
	logic                          out_valid_q;
	logic [efp_pkg::CNT_OUT_W-1:0] count_q;
	logic                          accept;
	logic                          retire;
	efp_pkg::token_t               map_tok;
	efp_pkg::token_t               recirc;
	efp_pkg::token_t               cell_in  [efp_pkg::NUM_CELLS];
	efp_pkg::token_t               cell_out [efp_pkg::NUM_CELLS];
	logic [efp_pkg::NUM_CELLS-1:0] cell_valid;
	efp_pkg::token_t               last_tok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.julia_mode      <= 1'b0;
			cfg_q.iteration_limit <= efp_pkg::RST_ITER_LIMIT;
			cfg_q.origin_re       <= efp_pkg::RST_ORIGIN;
			cfg_q.origin_im       <= efp_pkg::RST_ORIGIN;
			cfg_q.pixel_step      <= efp_pkg::RST_PIXEL_STEP;
			cfg_q.julia_c_re      <= '0;
			cfg_q.julia_c_im      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				efp_pkg::CFG_JULIA_MODE: cfg_q.julia_mode      <= cfg_data[0];
				efp_pkg::CFG_ITER_LIMIT: cfg_q.iteration_limit <= cfg_data[efp_pkg::LIM_W-1:0];
				efp_pkg::CFG_ORIGIN_RE:  cfg_q.origin_re       <= cfg_data;
				efp_pkg::CFG_ORIGIN_IM:  cfg_q.origin_im       <= cfg_data;
				efp_pkg::CFG_PIXEL_STEP: cfg_q.pixel_step      <= cfg_data[efp_pkg::STEP_W-1:0];
				efp_pkg::CFG_JULIA_C_RE: cfg_q.julia_c_re      <= cfg_data;
				efp_pkg::CFG_JULIA_C_IM: cfg_q.julia_c_im      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = busy_q;
	assign accept   = in_valid && !in_stall;

	efp_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.column  (column),
		.row     (row),
		.cfg     (cfg_q),
		.tok_out (map_tok)
	);

	assign last_tok = cell_out[efp_pkg::NUM_CELLS-1];
	// a finished token leaves the ring only when the output register can take it
	assign retire   = last_tok.valid && last_tok.done && (!out_valid_q || !out_stall);

	always_comb begin
		recirc = last_tok;
		if (retire) begin
			recirc.valid = 1'b0;
		end
	end

	assign cell_in[0] = map_tok.valid ? map_tok : recirc;

	for (genvar g = 0; g < efp_pkg::NUM_CELLS; g++) begin : g_cell
		if (g > 0) begin : g_link
			assign cell_in[g] = cell_out[g-1];
		end
		efp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.limit   (cfg_q.iteration_limit),
			.tok_in  (cell_in[g]),
			.tok_out (cell_out[g])
		);
		assign cell_valid[g] = cell_out[g].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (retire) begin
				busy_q <= 1'b0;
			end
			if (retire) begin
				out_valid_q <= 1'b1;
			end else if (out_stall == 1'b0) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			count_q <= last_tok.count[efp_pkg::CNT_OUT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign escape_count = count_q;

	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request accepted but block not busy");

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({map_tok.valid, cell_valid}))
		else $error("more than one token in flight");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !(map_tok.valid || (cell_valid != '0)))
		else $error("token in flight while idle");

	a_retire_output: assert property (@(posedge clk) disable iff (!arst_n)
		retire |=> (out_valid && !busy_q))
		else $error("retired token not presented");

endmodule

@@ bench/escape_time_fractal_pixel_top_tb.sv @@
// Self-checking bench for the escape-time fractal pixel block: directed table, then random views.
`timescale 1ns / 1ps

module escape_time_fractal_pixel_top_tb;
	import efp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
	localparam longint ESC_TWO  = longint'(2) << FRAC_BITS;
	localparam longint ESC_FOUR = longint'(4) << FRAC_BITS;
	localparam int     SEGMENTS = 8;
	localparam int     SEG_PIXELS = 119;

	typedef enum logic {ROW_REG, ROW_PIXEL} vec_kind_t;

	typedef struct packed {
		vec_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DAT_W-1:0]   data;
		logic [COL_W-1:0]       pix_col;
		logic [ROW_W-1:0]       pix_row;
		logic                   known;
		logic [CNT_OUT_W-1:0]   want;
	} vector_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DAT_W-1:0]   cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [COL_W-1:0]       column = '0;
	logic [ROW_W-1:0]       row = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [CNT_OUT_W-1:0]   escape_count;

	// bench copy of the view registers
	logic                      view_julia;
	logic [LIM_W-1:0]          view_limit;
	logic signed [COORD_W-1:0] view_re;
	logic signed [COORD_W-1:0] view_im;
	logic [STEP_W-1:0]         view_step;
	logic signed [COORD_W-1:0] const_re;
	logic signed [COORD_W-1:0] const_im;

	logic [CNT_OUT_W-1:0] pending_counts[$];
	vector_t              plan[$];
	int                   fail_count = 0;
	int                   sender_idle_pct = 0;
	int                   sink_stall_pct = 0;

	escape_time_fractal_pixel_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.column       (column),
		.row          (row),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.escape_count (escape_count)
	);

	always #5 clk = ~clk;

	function automatic logic [CNT_OUT_W-1:0] predict_escape(input logic [COL_W-1:0] c,
			input logic [ROW_W-1:0] r);
		longint pt_re, pt_im, zre, zim, kre, kim, sq_re, sq_im, prod_ri;
		int unsigned n;
		pt_re = longint'(view_re) + longint'(c) * longint'(view_step);
		pt_im = longint'(view_im) + longint'(r) * longint'(view_step);
		if (view_julia) begin
			zre = pt_re;
			zim = pt_im;
			kre = longint'(const_re);
			kim = longint'(const_im);
		end else begin
			zre = 0;
			zim = 0;
			kre = pt_re;
			kim = pt_im;
		end
		n = 0;
		while (n < view_limit) begin
			if (zre >= ESC_TWO || zre <= -ESC_TWO || zim >= ESC_TWO || zim <= -ESC_TWO)
				break;
			// |z| < 2 here, so the products fit and >>> floors toward minus infinity
			sq_re = (zre * zre) >>> FRAC_BITS;
			sq_im = (zim * zim) >>> FRAC_BITS;
			if (sq_re + sq_im >= ESC_FOUR)
				break;
			prod_ri = (zre * zim) >>> FRAC_BITS;
			zre = sq_re - sq_im + kre;
			zim = 2 * prod_ri + kim;
			n++;
		end
		return n[CNT_OUT_W-1:0];
	endfunction

	function automatic vector_t reg_vec(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		vector_t v;
		v = '0;
		v.kind = ROW_REG;
		v.idx = idx;
		v.data = data;
		return v;
	endfunction

	function automatic vector_t pix_vec(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
			input logic known, input logic [CNT_OUT_W-1:0] want);
		vector_t v;
		v = '0;
		v.kind = ROW_PIXEL;
		v.pix_col = c;
		v.pix_row = r;
		v.known = known;
		v.want = want;
		return v;
	endfunction

	task automatic note_failure(input string msg);
		if (fail_count < 10)
			$display("%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// called just after a rising edge; returns just after the edge that took the request
	task automatic send_pixel(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
			input logic known, input logic [CNT_OUT_W-1:0] want);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		column <= c;
		row <= r;
		do @(posedge clk); while (in_stall);
		pending_counts.push_back(known ? want : predict_escape(c, r));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_JULIA_MODE: view_julia = data[0];
			CFG_ITER_LIMIT: view_limit = data[LIM_W-1:0];
			CFG_ORIGIN_RE:  view_re = data;
			CFG_ORIGIN_IM:  view_im = data;
			CFG_PIXEL_STEP: view_step = data[STEP_W-1:0];
			CFG_JULIA_C_RE: const_re = data;
			CFG_JULIA_C_IM: const_im = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// random view: mostly around the interesting region, now and then anything at all
	task automatic program_view();
		logic [LIM_W-1:0] lim;
		case ($urandom_range(0, 9))
			0: lim = '0;
			1: lim = 16'd1;
			2: lim = 16'($urandom_range(256, 600));
			default: lim = 16'($urandom_range(2, 255));
		endcase
		write_reg(CFG_JULIA_MODE, $urandom);
		write_reg(CFG_ITER_LIMIT, {16'($urandom), lim});
		if ($urandom_range(0, 4) == 0) begin
			write_reg(CFG_ORIGIN_RE, $urandom);
			write_reg(CFG_ORIGIN_IM, $urandom);
			write_reg(CFG_PIXEL_STEP, $urandom);
		end else begin
			write_reg(CFG_ORIGIN_RE, 32'($urandom_range(0, 32'h3000_0000) - 32'h2800_0000));
			write_reg(CFG_ORIGIN_IM, 32'($urandom_range(0, 32'h2800_0000) - 32'h2000_0000));
			write_reg(CFG_PIXEL_STEP, {1'($urandom), 31'($urandom_range(1 << 18, 1 << 21))});
		end
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_JULIA_C_RE, $urandom);
			write_reg(CFG_JULIA_C_IM, $urandom);
		end else begin
			write_reg(CFG_JULIA_C_RE, 32'($urandom_range(0, 32'h2000_0000) - 32'h1000_0000));
			write_reg(CFG_JULIA_C_IM, 32'($urandom_range(0, 32'h2000_0000) - 32'h1000_0000));
		end
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_SPARE_IDX, $urandom);
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		logic [CNT_OUT_W-1:0] exp_count;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_counts.size() == 0) begin
				note_failure($sformatf("unexpected result escape_count=%0d", escape_count));
			end else begin
				exp_count = pending_counts.pop_front();
				if (escape_count !== exp_count)
					note_failure($sformatf("escape_count mismatch: expected %0d, got %0d",
						exp_count, escape_count));
			end
		end
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	initial begin
		#40_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		view_julia = 1'b0;
		view_limit = RST_ITER_LIMIT;
		view_re = RST_ORIGIN;
		view_im = RST_ORIGIN;
		view_step = RST_PIXEL_STEP;
		const_re = '0;
		const_im = '0;

		// defaults after reset: origin -2-2i, step about 0.01
		plan.push_back(pix_vec(10'd0, 10'd0, 1'b1, 8'd1));
		plan.push_back(pix_vec(10'd1023, 10'd1023, 1'b1, 8'd1));
		plan.push_back(pix_vec(10'd200, 10'd200, 1'b1, 8'd255));   // c just off zero
		plan.push_back(pix_vec(10'h155, 10'h2AA, 1'b0, '0));
		plan.push_back(pix_vec(10'h2AA, 10'h155, 1'b0, '0));
		plan.push_back(pix_vec(10'd150, 10'd200, 1'b0, '0));
		plan.push_back(reg_vec(CFG_ITER_LIMIT, 32'h0000_0000));
		plan.push_back(pix_vec(10'd200, 10'd200, 1'b1, 8'd0));
		// 256 iterations wrap to zero; upper data bits are dropped
		plan.push_back(reg_vec(CFG_ITER_LIMIT, 32'hABCD_0100));
		plan.push_back(reg_vec(CFG_ORIGIN_RE, 32'h0000_0000));
		plan.push_back(reg_vec(CFG_ORIGIN_IM, 32'h0000_0000));
		plan.push_back(pix_vec(10'd0, 10'd0, 1'b1, 8'd0));
		plan.push_back(reg_vec(CFG_PIXEL_STEP, 32'h8000_0000));     // zero step
		plan.push_back(pix_vec(10'd1023, 10'd1023, 1'b1, 8'd0));
		plan.push_back(reg_vec(CFG_PIXEL_STEP, 32'h7FFF_FFFF));
		plan.push_back(pix_vec(10'd1023, 10'd0, 1'b1, 8'd1));
		plan.push_back(pix_vec(10'd0, 10'd1023, 1'b1, 8'd1));
		plan.push_back(reg_vec(CFG_ITER_LIMIT, 32'hFFFF_FFFF));
		plan.push_back(pix_vec(10'd0, 10'd0, 1'b1, 8'd255));
		plan.push_back(reg_vec(CFG_ITER_LIMIT, 32'h0000_00FF));
		plan.push_back(reg_vec(CFG_ORIGIN_RE, 32'h8000_0000));
		plan.push_back(reg_vec(CFG_ORIGIN_IM, 32'h7FFF_FFFF));
		plan.push_back(pix_vec(10'd0, 10'd0, 1'b1, 8'd1));
		plan.push_back(reg_vec(CFG_ORIGIN_RE, 32'hE800_0000));
		plan.push_back(reg_vec(CFG_ORIGIN_IM, 32'hF800_0000));
		plan.push_back(reg_vec(CFG_PIXEL_STEP, 32'h0010_0000));
		plan.push_back(pix_vec(10'd100, 10'd128, 1'b0, '0));
		plan.push_back(pix_vec(10'd384, 10'd300, 1'b0, '0));
		// julia mode
		plan.push_back(reg_vec(CFG_JULIA_MODE, 32'hFFFF_FFFF));
		plan.push_back(reg_vec(CFG_JULIA_C_RE, 32'h0000_0000));
		plan.push_back(reg_vec(CFG_JULIA_C_IM, 32'h0000_0000));
		plan.push_back(pix_vec(10'd0, 10'd0, 1'b0, '0));
		plan.push_back(reg_vec(CFG_ORIGIN_RE, 32'hE000_0000));
		plan.push_back(pix_vec(10'd0, 10'd0, 1'b1, 8'd0));          // start on the boundary
		plan.push_back(pix_vec(10'd1023, 10'd1023, 1'b1, 8'd0));
		plan.push_back(reg_vec(CFG_JULIA_C_RE, 32'h8000_0000));
		plan.push_back(reg_vec(CFG_JULIA_C_IM, 32'h7FFF_FFFF));
		plan.push_back(reg_vec(CFG_ORIGIN_RE, 32'h0000_0000));
		plan.push_back(reg_vec(CFG_ORIGIN_IM, 32'h0000_0000));
		plan.push_back(pix_vec(10'd0, 10'd0, 1'b1, 8'd1));
		plan.push_back(reg_vec(CFG_JULIA_C_RE, 32'hF400_0000));
		plan.push_back(reg_vec(CFG_JULIA_C_IM, 32'h01C0_0000));
		plan.push_back(reg_vec(CFG_ORIGIN_RE, 32'hE800_0000));
		plan.push_back(reg_vec(CFG_ORIGIN_IM, 32'hE800_0000));
		plan.push_back(reg_vec(CFG_PIXEL_STEP, 32'h0018_0000));
		plan.push_back(pix_vec(10'd256, 10'd256, 1'b0, '0));
		plan.push_back(pix_vec(10'd512, 10'd300, 1'b0, '0));
		plan.push_back(pix_vec(10'h3FF, 10'h000, 1'b0, '0));
		plan.push_back(reg_vec(CFG_SPARE_IDX, 32'hFFFF_FFFF));      // must be ignored
		plan.push_back(pix_vec(10'd256, 10'd256, 1'b0, '0));
		plan.push_back(reg_vec(CFG_JULIA_MODE, 32'h0000_0000));
		plan.push_back(pix_vec(10'd300, 10'd256, 1'b0, '0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 37;
		sink_stall_pct = 37;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_pixel(plan[i].pix_col, plan[i].pix_row, plan[i].known, plan[i].want);
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin sender_idle_pct = 73; sink_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  sink_stall_pct = 73; end
				default: begin sender_idle_pct = 37; sink_stall_pct = 37; end
			endcase
			program_view();
			repeat (SEG_PIXELS)
				send_pixel(10'($urandom), 10'($urandom), 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ escape_time_fractal_pixel_top.f @@
hdl/efp_pkg.sv
hdl/efp_map.sv
hdl/efp_cell.sv
hdl/escape_time_fractal_pixel_top.sv
bench/escape_time_fractal_pixel_top_tb.sv
